>>> sv/bhi_pkg.sv
// Shared types and constants for the barycentric height interpolator.
package bhi_pkg;

    localparam int FIELD_W          = 32;
    localparam int COORD_WIDTH_DFLT = 32;

    typedef struct packed {
        logic signed [FIELD_W-1:0] v1_x;
        logic signed [FIELD_W-1:0] v1_h;
        logic signed [FIELD_W-1:0] v1_z;
        logic signed [FIELD_W-1:0] v2_x;
        logic signed [FIELD_W-1:0] v2_h;
        logic signed [FIELD_W-1:0] v2_z;
        logic signed [FIELD_W-1:0] v3_x;
        logic signed [FIELD_W-1:0] v3_h;
        logic signed [FIELD_W-1:0] v3_z;
        logic signed [FIELD_W-1:0] query_x;
        logic signed [FIELD_W-1:0] query_z;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_W-1:0] height;
        logic                      degenerate;
        logic                      saturated;
    } t_out_item;

    // control that travels with an item down the divider chain
    typedef struct packed {
        logic valid;
        logic degen;
        logic neg;
    } t_ctl;

endpackage

>>> sv/bhi_stream_if.sv
// Valid/ready stream channel carrying one payload per transfer.
interface bhi_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/bhi_front.sv
// Front pipeline: differences, determinant, numerators, weighted sum and magnitudes.
module bhi_front #(
    parameter int COORD_WIDTH = bhi_pkg::COORD_WIDTH_DFLT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  bhi_pkg::t_in_item                    i_item,
    output bhi_pkg::t_ctl                        o_ctl,
    output logic        [3*(COORD_WIDTH+1)+1:0]  o_rem,
    output logic        [2*(COORD_WIDTH+1):0]    o_dmag,
    output logic signed [COORD_WIDTH-1:0]        o_h3
);
    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;
    localparam int PW   = 2 * DW;
    localparam int DETW = PW + 1;
    localparam int PPW  = 2 * DW + 1;
    localparam int SW   = PPW + 1;
    localparam int NUMW = SW + DW;
    localparam int NSTG = 7;

    logic [NSTG-1:0] r_vld;

    logic signed [DW-1:0] s_x1, s_z1, s_h1, s_x2, s_z2, s_h2, s_x3, s_z3, s_h3, s_qx, s_qz;

    // stage 1
    logic signed [DW-1:0] r1_a, r1_b, r1_c, r1_e, r1_dqx, r1_dqz, r1_dh1, r1_dh2;
    // stage 2
    logic signed [PW-1:0] r2_ae, r2_bc, r2_adqx, r2_bdqz, r2_cdqx, r2_edqz;
    logic signed [DW-1:0] r2_dh1, r2_dh2;
    // stage 3
    logic signed [DETW-1:0] r3_det, r3_n1, r3_n2;
    logic signed [DW-1:0]   r3_dh1, r3_dh2;
    // stage 4
    logic signed [PPW-1:0] r4_p1l, r4_p1h, r4_p2l, r4_p2h;
    logic [DETW-1:0]       r4_dmag;
    logic                  r4_degen, r4_dneg;
    // stage 5
    logic signed [SW-1:0]  r5_hs, r5_ls;
    logic [DETW-1:0]       r5_dmag;
    logic                  r5_degen, r5_dneg;
    // stage 6
    logic signed [NUMW-1:0] r6_num;
    logic [DETW-1:0]        r6_dmag;
    logic                   r6_degen, r6_dneg;
    // stage 7
    logic [NUMW-1:0]        r7_mag;
    logic [DETW-1:0]        r7_dmag;
    logic                   r7_degen, r7_neg;

    logic signed [W-1:0]    r_h3 [NSTG];

    assign s_x1 = DW'($signed(i_item.v1_x[W-1:0]));
    assign s_h1 = DW'($signed(i_item.v1_h[W-1:0]));
    assign s_z1 = DW'($signed(i_item.v1_z[W-1:0]));
    assign s_x2 = DW'($signed(i_item.v2_x[W-1:0]));
    assign s_h2 = DW'($signed(i_item.v2_h[W-1:0]));
    assign s_z2 = DW'($signed(i_item.v2_z[W-1:0]));
    assign s_x3 = DW'($signed(i_item.v3_x[W-1:0]));
    assign s_h3 = DW'($signed(i_item.v3_h[W-1:0]));
    assign s_z3 = DW'($signed(i_item.v3_z[W-1:0]));
    assign s_qx = DW'($signed(i_item.query_x[W-1:0]));
    assign s_qz = DW'($signed(i_item.query_z[W-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= s_z2 - s_z3;
            r1_b   <= s_x3 - s_x2;
            r1_c   <= s_z3 - s_z1;
            r1_e   <= s_x1 - s_x3;
            r1_dqx <= s_qx - s_x3;
            r1_dqz <= s_qz - s_z3;
            r1_dh1 <= s_h1 - s_h3;
            r1_dh2 <= s_h2 - s_h3;
            r_h3[0] <= $signed(i_item.v3_h[W-1:0]);
            for (int k = 1; k < NSTG; k++) begin
                r_h3[k] <= r_h3[k-1];
            end

            r2_ae   <= r1_a * r1_e;
            r2_bc   <= r1_b * r1_c;
            r2_adqx <= r1_a * r1_dqx;
            r2_bdqz <= r1_b * r1_dqz;
            r2_cdqx <= r1_c * r1_dqx;
            r2_edqz <= r1_e * r1_dqz;
            r2_dh1  <= r1_dh1;
            r2_dh2  <= r1_dh2;

            r3_det <= DETW'(r2_ae) - DETW'(r2_bc);
            r3_n1  <= DETW'(r2_adqx) + DETW'(r2_bdqz);
            r3_n2  <= DETW'(r2_cdqx) + DETW'(r2_edqz);
            r3_dh1 <= r2_dh1;
            r3_dh2 <= r2_dh2;

            // split numerators so each product stays near 34 x 33
            r4_p1l   <= $signed({1'b0, r3_n1[DW-1:0]}) * r3_dh1;
            r4_p1h   <= $signed(r3_n1[DETW-1:DW]) * r3_dh1;
            r4_p2l   <= $signed({1'b0, r3_n2[DW-1:0]}) * r3_dh2;
            r4_p2h   <= $signed(r3_n2[DETW-1:DW]) * r3_dh2;
            r4_degen <= (r3_det == '0);
            r4_dneg  <= r3_det[DETW-1];
            r4_dmag  <= r3_det[DETW-1] ? DETW'(-r3_det) : DETW'(r3_det);

            r5_hs    <= SW'(r4_p1h) + SW'(r4_p2h);
            r5_ls    <= SW'(r4_p1l) + SW'(r4_p2l);
            r5_dmag  <= r4_dmag;
            r5_degen <= r4_degen;
            r5_dneg  <= r4_dneg;

            r6_num   <= $signed({r5_hs, {DW{1'b0}}}) + NUMW'(r5_ls);
            r6_dmag  <= r5_dmag;
            r6_degen <= r5_degen;
            r6_dneg  <= r5_dneg;

            r7_mag   <= r6_num[NUMW-1] ? NUMW'(-r6_num) : NUMW'(r6_num);
            r7_neg   <= r6_num[NUMW-1] ^ r6_dneg;
            r7_dmag  <= r6_dmag;
            r7_degen <= r6_degen;
        end
    end

    assign o_ctl  = '{valid: r_vld[NSTG-1], degen: r7_degen, neg: r7_neg};
    assign o_rem  = r7_mag;
    assign o_dmag = r7_dmag;
    assign o_h3   = r_h3[NSTG-1];

endmodule

>>> sv/bhi_div_cell.sv
// One restoring-division cell: decides one quotient bit and passes the item on.
module bhi_div_cell #(
    parameter int COORD_WIDTH = bhi_pkg::COORD_WIDTH_DFLT,
    parameter int SHIFT       = 0
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  bhi_pkg::t_ctl                        i_ctl,
    input  logic        [3*(COORD_WIDTH+1)+1:0]  i_rem,
    input  logic        [2*(COORD_WIDTH+1):0]    i_dmag,
    input  logic        [COORD_WIDTH+1:0]        i_q,
    input  logic signed [COORD_WIDTH-1:0]        i_h3,
    output bhi_pkg::t_ctl                        o_ctl,
    output logic        [3*(COORD_WIDTH+1)+1:0]  o_rem,
    output logic        [2*(COORD_WIDTH+1):0]    o_dmag,
    output logic        [COORD_WIDTH+1:0]        o_q,
    output logic signed [COORD_WIDTH-1:0]        o_h3
);
    localparam int DW   = COORD_WIDTH + 1;
    localparam int NUMW = 3 * DW + 2;
    localparam int QW   = DW + 1;

    logic [NUMW-1:0] s_dsh;
    logic            s_ge;
    logic [NUMW-1:0] n_rem;
    logic [QW-1:0]   n_q;

    bhi_pkg::t_ctl          r_ctl;
    logic [NUMW-1:0]        r_rem;
    logic [2*DW:0]          r_dmag;
    logic [QW-1:0]          r_q;
    logic signed [COORD_WIDTH-1:0] r_h3;

    always_comb begin
        s_dsh = NUMW'(i_dmag) << SHIFT;
        s_ge  = (i_rem >= s_dsh);
        n_rem = s_ge ? (i_rem - s_dsh) : i_rem;
        n_q   = i_q;
        n_q[SHIFT] = s_ge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_dmag <= i_dmag;
            r_q    <= n_q;
            r_h3   <= i_h3;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_rem  = r_rem;
    assign o_dmag = r_dmag;
    assign o_q    = r_q;
    assign o_h3   = r_h3;

endmodule

>>> sv/barycentric_height_interpolate.sv
// Top level: barycentric height interpolation, front pipeline plus divider cell chain.
//
//  channel   dir  payload                                   transfer when
//  i_in      in   v1..v3 (x, h, z), query_x, query_z        i_in.valid && i_in.ready
//  o_out     out  height, degenerate, saturated             o_out.valid && o_out.ready
//
//  One item per cycle sustained while the output buffer has room; 7 front stages,
//  COORD_WIDTH + 2 divider cells, one output register.
//  The divider chain (one quotient bit per cell) sets the depth.
//  Reset clears all valid bits; no state survives between items.
//  A two-entry output buffer absorbs one result under stall; i_in.ready drops
//  only while the second entry is full, and the whole pipeline holds then.
module barycentric_height_interpolate #(
    parameter int COORD_WIDTH = bhi_pkg::COORD_WIDTH_DFLT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bhi_stream_if.sink    i_in,
    bhi_stream_if.source  o_out
);
    localparam int W     = COORD_WIDTH;
    localparam int DW    = W + 1;
    localparam int DETW  = 2 * DW + 1;
    localparam int NUMW  = 3 * DW + 2;
    localparam int QW    = DW + 1;
    localparam int NCELL = QW;
    localparam int HW    = W + 3;

    logic en;

    bhi_pkg::t_ctl          c_ctl  [NCELL+1];
    logic [NUMW-1:0]        c_rem  [NCELL+1];
    logic [DETW-1:0]        c_dmag [NCELL+1];
    logic [QW-1:0]          c_q    [NCELL+1];
    logic signed [W-1:0]    c_h3   [NCELL+1];

    logic                   s_ovf;
    logic signed [HW-1:0]   s_qv;
    logic signed [HW-1:0]   s_hv;
    logic                   s_fits;
    logic signed [W-1:0]    s_hw;
    bhi_pkg::t_out_item     n_res;

    logic                   r_out_valid;
    logic                   r_skid_valid;
    bhi_pkg::t_out_item     r_out;
    bhi_pkg::t_out_item     r_skid;

    assign en         = !r_skid_valid;
    assign i_in.ready = en;

    bhi_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_ctl   (c_ctl[0]),
        .o_rem   (c_rem[0]),
        .o_dmag  (c_dmag[0]),
        .o_h3    (c_h3[0])
    );

    assign c_q[0] = '0;

    // first cell tests quotient >= 2^DW (overflow), then one bit per cell downward
    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        bhi_div_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .SHIFT       (NCELL - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (c_ctl[j]),
            .i_rem   (c_rem[j]),
            .i_dmag  (c_dmag[j]),
            .i_q     (c_q[j]),
            .i_h3    (c_h3[j]),
            .o_ctl   (c_ctl[j+1]),
            .o_rem   (c_rem[j+1]),
            .o_dmag  (c_dmag[j+1]),
            .o_q     (c_q[j+1]),
            .o_h3    (c_h3[j+1])
        );
    end

    always_comb begin
        s_ovf  = c_q[NCELL][QW-1];
        s_qv   = HW'(c_q[NCELL][QW-2:0]);
        s_hv   = HW'(c_h3[NCELL]) + (c_ctl[NCELL].neg ? -s_qv : s_qv);
        s_fits = (s_hv[HW-1:W-1] == '0) || (s_hv[HW-1:W-1] == '1);
        if (s_ovf) begin
            s_hw = c_ctl[NCELL].neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else if (!s_fits) begin
            s_hw = s_hv[HW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            s_hw = s_hv[W-1:0];
        end
        if (c_ctl[NCELL].degen) begin
            n_res.height     = '0;
            n_res.degenerate = 1'b1;
            n_res.saturated  = 1'b0;
        end else begin
            n_res.height     = bhi_pkg::FIELD_W'(s_hw);
            n_res.degenerate = 1'b0;
            n_res.saturated  = s_ovf || !s_fits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (o_out.ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || o_out.ready) begin
            r_out_valid <= c_ctl[NCELL].valid;
        end else if (c_ctl[NCELL].valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (o_out.ready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || o_out.ready) begin
            r_out <= n_res;
        end else begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

>>> sv/bhi_checker.sv
// Port-level checks for the barycentric height interpolator, bound to the top level.
module bhi_checker #(
    parameter int COORD_WIDTH = bhi_pkg::COORD_WIDTH_DFLT
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input bhi_pkg::t_out_item i_out_data
);
    localparam int FW = bhi_pkg::FIELD_W;
    localparam logic [FW-1:0] HMAX = {{(FW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [FW-1:0] HMIN = ~HMAX;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed or dropped under stall");

    a_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.degenerate |->
            i_out_data.height == '0 && !i_out_data.saturated)
        else $error("degenerate result not zero or marked saturated");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.saturated |->
            i_out_data.height == HMAX || i_out_data.height == HMIN)
        else $error("saturated result not at a range bound");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked with output empty");

endmodule

bind barycentric_height_interpolate bhi_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_bhi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Testbench for barycentric_height_interpolate: directed and random triangles.
module testbench;

    localparam int     COORD_W     = bhi_pkg::COORD_WIDTH_DFLT;
    localparam int     LATENCY     = COORD_W + 10;
    localparam int     IDLE_LIMIT  = 4000;
    localparam int     N_RANDOM    = 1100;
    localparam int     HOLD_CYCLES = 250;
    localparam int     ONE         = 65536;
    localparam int     PMAX        = 32'h7FFF_FFFF;
    localparam int     PMIN        = 32'h8000_0000;
    localparam longint H_MAX       = 64'sd2147483647;
    localparam longint H_MIN       = -64'sd2147483648;

    localparam bhi_pkg::t_out_item DEGEN_RES = '{height: '0, degenerate: 1'b1, saturated: 1'b0};

    typedef struct {
        bhi_pkg::t_in_item  item;
        bit                 typed;
        bhi_pkg::t_out_item want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bhi_stream_if #(.t_data(bhi_pkg::t_in_item))  tri_ch ();
    bhi_stream_if #(.t_data(bhi_pkg::t_out_item)) height_ch ();

    barycentric_height_interpolate #(.COORD_WIDTH(COORD_W)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tri_ch),
        .o_out   (height_ch)
    );

    bhi_pkg::t_out_item height_q[$];
    t_dir_row           directed_rows[$];
    int                 sent_cnt    = 0;
    int                 checked_cnt = 0;
    int                 degen_cnt   = 0;
    int                 sat_cnt     = 0;
    int                 fail_cnt    = 0;
    int                 hold_cnt    = 0;
    int                 idle_cycles = 0;
    bit                 steady      = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact height: h3 + (n1*(h1-h3) + n2*(h2-h3)) / det, truncated, then clamped
    function automatic bhi_pkg::t_out_item interp_height(bhi_pkg::t_in_item it);
        longint              x1, h1, z1, x2, h2, z2, x3, h3, z3, qx, qz, qv, hv;
        logic signed [127:0] a, b, c, e, dqx, dqz, det, n1, n2, num;
        logic [127:0]        num_mag, det_mag, quot;
        bhi_pkg::t_out_item  r;
        x1 = longint'($signed(it.v1_x));
        h1 = longint'($signed(it.v1_h));
        z1 = longint'($signed(it.v1_z));
        x2 = longint'($signed(it.v2_x));
        h2 = longint'($signed(it.v2_h));
        z2 = longint'($signed(it.v2_z));
        x3 = longint'($signed(it.v3_x));
        h3 = longint'($signed(it.v3_h));
        z3 = longint'($signed(it.v3_z));
        qx = longint'($signed(it.query_x));
        qz = longint'($signed(it.query_z));
        a   = z2 - z3;
        b   = x3 - x2;
        c   = z3 - z1;
        e   = x1 - x3;
        dqx = qx - x3;
        dqz = qz - z3;
        det = a * e - b * c;
        r   = '0;
        if (det == 0) begin
            r.degenerate = 1'b1;
        end else begin
            n1      = a * dqx + b * dqz;
            n2      = c * dqx + e * dqz;
            num     = n1 * (h1 - h3) + n2 * (h2 - h3);
            num_mag = num[127] ? -num : num;
            det_mag = det[127] ? -det : det;
            quot    = num_mag / det_mag;
            if (quot >= (128'd1 << 62))
                qv = longint'(64'd1 << 62);
            else
                qv = longint'(quot[63:0]);
            if (num[127] != det[127])
                qv = -qv;
            hv = h3 + qv;
            if (hv > H_MAX) begin
                r.height    = PMAX;
                r.saturated = 1'b1;
            end else if (hv < H_MIN) begin
                r.height    = PMIN;
                r.saturated = 1'b1;
            end else begin
                r.height = hv[31:0];
            end
        end
        return r;
    endfunction

    function automatic bhi_pkg::t_in_item tri_item(int x1, int h1, int z1, int x2, int h2, int z2,
                                                   int x3, int h3, int z3, int qx, int qz);
        bhi_pkg::t_in_item t;
        t.v1_x    = x1;
        t.v1_h    = h1;
        t.v1_z    = z1;
        t.v2_x    = x2;
        t.v2_h    = h2;
        t.v2_z    = z2;
        t.v3_x    = x3;
        t.v3_h    = h3;
        t.v3_z    = z3;
        t.query_x = qx;
        t.query_z = qz;
        return t;
    endfunction

    function automatic int rnd_signed(int bits);
        return int'($urandom) >>> (32 - bits);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 7))
            0:       return PMIN;
            1:       return PMAX;
            2:       return 0;
            3:       return -1;
            4:       return 1;
            5:       return ONE;
            6:       return -ONE;
            default: return int'($urandom);
        endcase
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    task automatic send_tri(bhi_pkg::t_in_item it, bit typed, bhi_pkg::t_out_item want);
        bhi_pkg::t_out_item exp_r;
        int                 gap;
        exp_r = typed ? want : interp_height(it);
        gap   = steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            tri_ch.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        tri_ch.valid = 1'b1;
        tri_ch.data  = it;
        do @(posedge i_clk); while (!tri_ch.ready);
        height_q.push_back(exp_r);
        sent_cnt++;
        degen_cnt += exp_r.degenerate;
        sat_cnt   += exp_r.saturated;
    endtask

    // receiver: random stalls, two long hold-offs, no stalls in the steady window
    initial begin
        int stall;
        stall = 0;
        height_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_cnt < 2 && sent_cnt >= 300 + 400 * hold_cnt) begin
                height_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_cnt++;
            end
            if (steady || stall == 0) begin
                height_ch.ready = 1'b1;
                if (!steady)
                    stall = pick_gap();
            end else begin
                height_ch.ready = 1'b0;
                stall--;
            end
        end
    end

    always @(posedge i_clk) begin
        bhi_pkg::t_out_item exp_r;
        if (i_rst_n && height_ch.valid && height_ch.ready) begin
            if (height_q.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result: h=%h deg=%b sat=%b", height_ch.data.height,
                             height_ch.data.degenerate, height_ch.data.saturated);
            end else begin
                exp_r = height_q.pop_front();
                checked_cnt++;
                if (height_ch.data.height !== exp_r.height ||
                    height_ch.data.degenerate !== exp_r.degenerate ||
                    height_ch.data.saturated !== exp_r.saturated) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("mismatch %0d: want h=%h deg=%b sat=%b, got h=%h deg=%b sat=%b",
                                 checked_cnt, exp_r.height, exp_r.degenerate, exp_r.saturated,
                                 height_ch.data.height, height_ch.data.degenerate,
                                 height_ch.data.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tri_ch.valid && tri_ch.ready) || (height_ch.valid && height_ch.ready)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, height_q.size());
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        int x[3], h[3], z[3];
        int qx, qz, kind, cx, cz, s, dx, dz, k, w1, w2, w3;

        i_rst_n      = 1'b0;
        tri_ch.valid = 1'b0;
        tri_ch.data  = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero-area triangles first
        directed_rows.push_back('{tri_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, DEGEN_RES});
        directed_rows.push_back('{tri_item(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX,
                                           PMAX, PMAX), 1'b1, DEGEN_RES});
        directed_rows.push_back('{tri_item(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN,
                                           PMIN, PMIN), 1'b1, DEGEN_RES});
        directed_rows.push_back('{tri_item(0, 5, 0, ONE, 7, ONE, 2 * ONE, 9, 2 * ONE, 3, 4),
                                  1'b1, DEGEN_RES});
        directed_rows.push_back('{tri_item(ONE, 1, ONE, 0, 2, 5, ONE, 3, ONE, PMAX, PMIN),
                                  1'b1, DEGEN_RES});
        // unit triangle: v1=(1,0), v2=(0,1), v3=(0,0) in x-z
        directed_rows.push_back('{tri_item(ONE, 32'h1234_5678, 0, 0, -5, ONE, 0, 32'h0BAD_F00D, 0,
                                           0, 0), 1'b1,
                                  bhi_pkg::t_out_item'{32'h0BAD_F00D, 1'b0, 1'b0}});
        directed_rows.push_back('{tri_item(ONE, 32'h1234_5678, 0, 0, -5, ONE, 0, 32'h0BAD_F00D, 0,
                                           ONE, 0), 1'b1,
                                  bhi_pkg::t_out_item'{32'h1234_5678, 1'b0, 1'b0}});
        directed_rows.push_back('{tri_item(ONE, 32'h1234_5678, 0, 0, -5, ONE, 0, 32'h0BAD_F00D, 0,
                                           0, ONE), 1'b1,
                                  bhi_pkg::t_out_item'{-32'sd5, 1'b0, 1'b0}});
        directed_rows.push_back('{tri_item(ONE, PMAX, 0, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0),
                                  1'b1, bhi_pkg::t_out_item'{PMAX, 1'b0, 1'b1}});
        directed_rows.push_back('{tri_item(ONE, PMIN, 0, 0, 0, ONE, 0, 0, 0, 2 * ONE, 0),
                                  1'b1, bhi_pkg::t_out_item'{PMIN, 1'b0, 1'b1}});
        directed_rows.push_back('{tri_item(ONE, PMAX, 0, 0, 0, ONE, 0, PMIN, 0, PMAX, 0),
                                  1'b0, '0});
        directed_rows.push_back('{tri_item(ONE, PMIN, 0, 0, PMAX, ONE, 0, 0, 0, PMIN, PMIN),
                                  1'b0, '0});
        directed_rows.push_back('{tri_item(ONE, 3, 0, 0, -3, ONE, 0, 0, 0, ONE / 3, ONE / 3),
                                  1'b0, '0});
        directed_rows.push_back('{tri_item(2, -3, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, '0});
        directed_rows.push_back('{tri_item(PMAX, PMAX, PMIN, PMIN, PMIN, PMAX, PMIN, 0, PMIN,
                                           PMAX, PMAX), 1'b0, '0});
        directed_rows.push_back('{tri_item(PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, PMIN, PMAX, PMIN,
                                           0, 0), 1'b0, '0});
        directed_rows.push_back('{tri_item(PMAX, PMAX, 0, 0, PMAX, PMAX, PMIN, PMIN, PMIN, -1, -1),
                                  1'b0, '0});
        // clockwise winding, query on v1
        directed_rows.push_back('{tri_item(0, -32'sh12345, ONE, ONE, 77, 0, 0, -9, 0, 0, ONE),
                                  1'b1, bhi_pkg::t_out_item'{-32'sh12345, 1'b0, 1'b0}});
        directed_rows.push_back('{tri_item(32'h1357_9BDF, 32'h2468_ACE0, -32'sh0F0F_0F0F,
                                           -32'sh5555_5555, 32'h0000_FFFF, 32'h3333_3333,
                                           32'h0123_4567, -32'sh0765_4321, -32'sh2222_2222,
                                           -1, 32'h7000_0000), 1'b0, '0});

        foreach (directed_rows[i])
            send_tri(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            steady = (n >= 500 && n < 600);
            kind   = $urandom_range(0, 99);
            if (kind < 40) begin
                // query inside the triangle, sometimes pushed outside
                cx = rnd_signed(28);
                cz = rnd_signed(28);
                s  = $urandom_range(4, 24);
                for (int v = 0; v < 3; v++) begin
                    x[v] = cx + rnd_signed(s);
                    z[v] = cz + rnd_signed(s);
                    h[v] = $urandom_range(0, 1) ? int'($urandom) : rnd_signed(20);
                end
                w1 = $urandom_range(0, 256);
                w2 = $urandom_range(0, 256 - w1);
                w3 = 256 - w1 - w2;
                qx = int'((longint'(w1) * x[0] + longint'(w2) * x[1] + longint'(w3) * x[2]) / 256);
                qz = int'((longint'(w1) * z[0] + longint'(w2) * z[1] + longint'(w3) * z[2]) / 256);
                if ($urandom_range(0, 3) == 0) begin
                    qx += rnd_signed(s + 1);
                    qz += rnd_signed(s + 1);
                end
            end else if (kind < 55) begin
                // zero area: collinear or repeated vertex
                x[0] = rnd_signed(28);
                z[0] = rnd_signed(28);
                dx   = rnd_signed(12);
                dz   = rnd_signed(12);
                k    = int'($urandom_range(0, 16)) - 8;
                if ($urandom_range(0, 1)) begin
                    x[1] = x[0] + dx;
                    z[1] = z[0] + dz;
                    x[2] = x[0] + k * dx;
                    z[2] = z[0] + k * dz;
                end else begin
                    x[1] = rnd_signed(28);
                    z[1] = rnd_signed(28);
                    x[2] = x[0];
                    z[2] = z[0];
                end
                for (int v = 0; v < 3; v++)
                    h[v] = int'($urandom);
                qx = int'($urandom);
                qz = int'($urandom);
            end else if (kind < 70) begin
                s = $urandom_range(2, 10);
                for (int v = 0; v < 3; v++) begin
                    x[v] = rnd_signed(s);
                    z[v] = rnd_signed(s);
                    h[v] = $urandom_range(0, 1) ? rnd_signed(12) : int'($urandom);
                end
                qx = rnd_signed(s + 1);
                qz = rnd_signed(s + 1);
            end else if (kind < 85) begin
                for (int v = 0; v < 3; v++) begin
                    x[v] = pick_extreme();
                    z[v] = pick_extreme();
                    h[v] = pick_extreme();
                end
                qx = pick_extreme();
                qz = pick_extreme();
            end else begin
                for (int v = 0; v < 3; v++) begin
                    x[v] = int'($urandom);
                    z[v] = int'($urandom);
                    h[v] = int'($urandom);
                end
                qx = int'($urandom);
                qz = int'($urandom);
            end
            send_tri(tri_item(x[0], h[0], z[0], x[1], h[1], z[1], x[2], h[2], z[2], qx, qz),
                     1'b0, '0);
        end
        steady = 1'b0;

        @(negedge i_clk);
        tri_ch.valid = 1'b0;
        while (height_q.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d triangles sent (%0d directed), %0d heights checked, %0d mismatches",
                 sent_cnt, directed_rows.size(), checked_cnt, fail_cnt);
        $display("%0d degenerate, %0d clamped, %0d long output hold-offs",
                 degen_cnt, sat_cnt, hold_cnt);
        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
